>>> design/c8x_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// c8x_pkg
// Shared types and constants for the CHIP-8 execute unit.
// ----------------------------------------------------------------------------
package c8x_pkg;

    localparam logic [1:0] CMD_EXEC   = 2'd0;
    localparam logic [1:0] CMD_WRMEM  = 2'd1;
    localparam logic [1:0] CMD_RDPIX  = 2'd2;
    localparam logic [1:0] CMD_UNUSED = 2'd3;

    localparam logic [11:0] PC_START = 12'h200;

    localparam logic [3:0] OP_JP   = 4'h1;
    localparam logic [3:0] OP_LD   = 4'h6;
    localparam logic [3:0] OP_ADD  = 4'h7;
    localparam logic [3:0] OP_ALU  = 4'h8;
    localparam logic [3:0] OP_SNE  = 4'h9;
    localparam logic [3:0] OP_LDI  = 4'hA;
    localparam logic [3:0] OP_JPV0 = 4'hB;
    localparam logic [3:0] OP_RND  = 4'hC;
    localparam logic [3:0] OP_DRW  = 4'hD;

    localparam logic [3:0] ALU_MOV = 4'h0;
    localparam logic [3:0] ALU_OR  = 4'h1;
    localparam logic [3:0] ALU_AND = 4'h2;
    localparam logic [3:0] ALU_XOR = 4'h3;
    localparam logic [3:0] ALU_ADD = 4'h4;
    localparam logic [3:0] ALU_SUB = 4'h5;
    localparam logic [3:0] ALU_SHR = 4'h6;
    localparam logic [3:0] ALU_SBN = 4'h7;
    localparam logic [3:0] ALU_SHL = 4'hE;

    localparam logic [3:0] FLAG_REG = 4'hF;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] opcode;
        logic [7:0]  random_byte;
        logic [11:0] mem_address;
        logic [7:0]  mem_data;
        logic [5:0]  pixel_x;
        logic [4:0]  pixel_y;
    } in_item_t;

    typedef struct packed {
        logic [11:0] program_counter;
        logic [11:0] index_value;
        logic [7:0]  flag_value;
        logic        pixel_value;
    } out_item_t;

endpackage

>>> design/c8x_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_front
// Accepts requests and holds them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
module c8x_front (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire c8x_pkg::in_item_t s_data,
    output logic                   q_valid,
    input  wire logic              q_ready,
    output c8x_pkg::in_item_t      q_data
);

    c8x_pkg::in_item_t slot_reg [2];
    logic              wr_ptr_reg, rd_ptr_reg;
    logic [1:0]        count_reg;
    logic              push, pop;

    assign s_ready = (count_reg != 2'd2);
    assign q_valid = (count_reg != 2'd0);
    assign q_data  = slot_reg[rd_ptr_reg];
    assign push    = s_valid && s_ready;
    assign pop     = q_valid && q_ready;

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= s_data;
        end
    end

    // Queue pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            if (push) wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)  rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_reg + {1'b0, push} - {1'b0, pop};
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= 2'd2) else $error("queue count out of range");
    a_full_blocks: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == 2'd2 |-> !s_ready) else $error("accept while full");
    a_pop_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |-> count_reg != 2'd0) else $error("pop while empty");
`endif

endmodule
`default_nettype wire

>>> design/c8x_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// c8x_back
// Executes queued requests: ALU ops, jumps, memory writes, pixel reads and
// row-serial sprite drawing. Clears the frame after reset.
// ----------------------------------------------------------------------------
module c8x_back (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    output logic                   q_ready,
    input  wire c8x_pkg::in_item_t q_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output c8x_pkg::out_item_t     m_data
);

    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_PIX   = 3'd2;
    localparam logic [2:0] ST_DRAW  = 3'd3;
    localparam logic [2:0] ST_DRAW2 = 3'd4;
    localparam logic [2:0] ST_OUT   = 3'd5;

    logic [2:0]  state_reg;
    logic [7:0]  vreg_reg [16];
    logic [11:0] pc_reg, index_reg;

    // Memory and frame (one 64-bit row per word).
    logic [7:0]  mem [4096];
    logic [63:0] frame [32];
    logic [7:0]  mem_rd_reg;
    logic [63:0] row_rd_reg;

    logic [4:0]  clr_reg;
    logic [3:0]  n_reg, row_reg;
    logic [5:0]  ox_reg;
    logic [4:0]  oy_reg;
    logic        coll_reg;
    logic [5:0]  pix_x_reg;
    logic        pixel_reg;

    c8x_pkg::out_item_t out_reg;
    logic               out_valid_reg;

    logic [3:0]  top, x, y, n;
    logic [7:0]  nn, vx, vy;
    logic [8:0]  sum9;
    logic        take;

    assign top = q_data.opcode[15:12];
    assign x   = q_data.opcode[11:8];
    assign y   = q_data.opcode[7:4];
    assign n   = q_data.opcode[3:0];
    assign nn  = q_data.opcode[7:0];
    assign vx  = vreg_reg[x];
    assign vy  = vreg_reg[y];
    assign sum9 = {1'b0, vx} + {1'b0, vy};

    assign q_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign take    = q_valid && q_ready;
    assign m_valid = out_valid_reg;
    assign m_data  = out_reg;

    // Sprite row addressing.
    logic [4:0]  cur_y;
    logic [11:0] mem_addr;
    logic [63:0] spr_mask;
    logic [63:0] wide;
    assign cur_y    = oy_reg + {1'b0, row_reg};
    assign mem_addr = index_reg + {8'd0, row_reg};
    assign wide     = {mem_rd_reg, 56'd0};
    // Rotate so sprite bit 7 lands at column ox; column c is bit 63-c.
    assign spr_mask = (wide >> ox_reg) | (wide << (7'd64 - {1'b0, ox_reg}));

    // Frame and memory ports.
    logic        frame_we;
    logic [4:0]  frame_wa;
    logic [63:0] frame_wd;
    logic [4:0]  frame_ra;
    always_comb begin
        frame_we = 1'b0;
        frame_wa = cur_y;
        frame_wd = row_rd_reg ^ spr_mask;
        frame_ra = cur_y;
        if (state_reg == ST_CLEAR) begin
            frame_we = 1'b1;
            frame_wa = clr_reg;
            frame_wd = '0;
        end else if (state_reg == ST_DRAW2) begin
            frame_we = 1'b1;
        end else if (take) begin
            frame_ra = q_data.pixel_y;
        end
    end

    always_ff @(posedge aclk) begin
        if (frame_we) frame[frame_wa] <= frame_wd;
        row_rd_reg <= frame[frame_ra];
    end

    always_ff @(posedge aclk) begin
        if (take && q_data.cmd == c8x_pkg::CMD_WRMEM) begin
            mem[q_data.mem_address] <= q_data.mem_data;
        end
        mem_rd_reg <= mem[(state_reg == ST_IDLE) ? index_reg : mem_addr];
    end

    // Control and architectural state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            out_valid_reg <= 1'b0;
            pc_reg        <= c8x_pkg::PC_START;
            index_reg     <= '0;
            for (int i = 0; i < 16; i++) vreg_reg[i] <= '0;
        end else begin
            if (m_valid && m_ready) out_valid_reg <= 1'b0;
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 5'd1;
                    if (clr_reg == 5'd31) state_reg <= ST_IDLE;
                end
                ST_IDLE: begin
                    if (take) begin
                        pixel_reg <= 1'b0;
                        state_reg <= ST_OUT;
                        if (q_data.cmd == c8x_pkg::CMD_RDPIX) begin
                            pix_x_reg <= q_data.pixel_x;
                            state_reg <= ST_PIX;
                        end else if (q_data.cmd == c8x_pkg::CMD_EXEC) begin
                            unique case (top)
                                c8x_pkg::OP_JP:   pc_reg <= q_data.opcode[11:0];
                                c8x_pkg::OP_LD:   vreg_reg[x] <= nn;
                                c8x_pkg::OP_ADD:  vreg_reg[x] <= vx + nn;
                                c8x_pkg::OP_SNE:  if (vx != vy) pc_reg <= pc_reg + 12'd2;
                                c8x_pkg::OP_LDI:  index_reg <= q_data.opcode[11:0];
                                c8x_pkg::OP_JPV0: pc_reg <= {4'd0, vreg_reg[0]}
                                                        + q_data.opcode[11:0];
                                c8x_pkg::OP_RND:  vreg_reg[x] <= nn & q_data.random_byte;
                                c8x_pkg::OP_DRW: begin
                                    vreg_reg[c8x_pkg::FLAG_REG] <= 8'd0;
                                    ox_reg   <= vx[5:0];
                                    oy_reg   <= vy[4:0];
                                    n_reg    <= n;
                                    row_reg  <= 4'd0;
                                    coll_reg <= 1'b0;
                                    if (n != 4'd0) state_reg <= ST_DRAW;
                                end
                                c8x_pkg::OP_ALU: begin
                                    unique case (n)
                                        c8x_pkg::ALU_MOV: vreg_reg[x] <= vy;
                                        c8x_pkg::ALU_OR:  vreg_reg[x] <= vx | vy;
                                        c8x_pkg::ALU_AND: vreg_reg[x] <= vx & vy;
                                        c8x_pkg::ALU_XOR: vreg_reg[x] <= vx ^ vy;
                                        c8x_pkg::ALU_ADD: begin
                                            vreg_reg[c8x_pkg::FLAG_REG] <= {7'd0, sum9[8]};
                                            vreg_reg[x] <= sum9[7:0];
                                        end
                                        c8x_pkg::ALU_SUB: begin
                                            vreg_reg[c8x_pkg::FLAG_REG] <=
                                                {7'd0, vx >= vy};
                                            vreg_reg[x] <= vx - vy;
                                        end
                                        c8x_pkg::ALU_SHR: begin
                                            vreg_reg[c8x_pkg::FLAG_REG] <= {7'd0, vx[0]};
                                            vreg_reg[x] <= {1'b0, vx[7:1]};
                                        end
                                        c8x_pkg::ALU_SBN: begin
                                            vreg_reg[c8x_pkg::FLAG_REG] <=
                                                {7'd0, vy >= vx};
                                            vreg_reg[x] <= vy - vx;
                                        end
                                        c8x_pkg::ALU_SHL: begin
                                            vreg_reg[c8x_pkg::FLAG_REG] <= {7'd0, vx[7]};
                                            vreg_reg[x] <= {vx[6:0], 1'b0};
                                        end
                                        default: ;
                                    endcase
                                end
                                default: ;
                            endcase
                        end
                    end
                end
                ST_PIX: begin
                    pixel_reg <= row_rd_reg[6'd63 - pix_x_reg];
                    state_reg <= ST_OUT;
                end
                ST_DRAW: begin
                    // Memory byte and frame row for this row are being read.
                    state_reg <= ST_DRAW2;
                end
                ST_DRAW2: begin
                    if (|(row_rd_reg & spr_mask)) begin
                        vreg_reg[c8x_pkg::FLAG_REG] <= 8'd1;
                    end
                    row_reg <= row_reg + 4'd1;
                    if (row_reg + 4'd1 == n_reg) state_reg <= ST_OUT;
                    else                         state_reg <= ST_DRAW;
                end
                ST_OUT: begin
                    out_reg.program_counter <= pc_reg;
                    out_reg.index_value     <= index_reg;
                    out_reg.flag_value      <= vreg_reg[c8x_pkg::FLAG_REG];
                    out_reg.pixel_value     <= pixel_reg;
                    out_valid_reg           <= 1'b1;
                    state_reg               <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

`ifndef SYNTH
    a_no_take_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        take |-> state_reg == ST_IDLE && !out_valid_reg)
        else $error("request taken while busy");
    a_draw_rows: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_DRAW2 |-> row_reg < n_reg) else $error("row overrun");
    a_out_from_out: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(out_valid_reg) |-> $past(state_reg) == ST_OUT)
        else $error("result without finish");
`endif

endmodule
`default_nettype wire

>>> design/chip8_execute_with_sprite_draw_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// chip8_execute_with_sprite_draw_unit
// CHIP-8 execute unit with memory, frame buffer and sprite drawing.
// ----------------------------------------------------------------------------
// Channel  Ports              Direction  Carries
// input    s_valid/s_ready    in         command, opcode, operands
// result   m_valid/m_ready    out        PC, index, VF, pixel
//
// An ALU op, jump, memory write or unused command passes through ST_IDLE and
// ST_OUT; a pixel read adds ST_PIX; DXYN visits ST_DRAW and ST_DRAW2 once per
// sprite row. After reset the frame's 32 rows are cleared, one row a cycle,
// while requests wait in the two-entry queue. The queue keeps accepting, up
// to two entries, while a result is stalled.
// ----------------------------------------------------------------------------
module chip8_execute_with_sprite_draw_unit (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              s_valid,
    output logic                   s_ready,
    input  wire c8x_pkg::in_item_t s_data,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output c8x_pkg::out_item_t     m_data
);

    logic              q_valid, q_ready;
    c8x_pkg::in_item_t q_data;

    c8x_front u_front (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data)
    );

    c8x_back u_back (
        .aclk(aclk), .aresetn(aresetn),
        .q_valid(q_valid), .q_ready(q_ready), .q_data(q_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data)
    );

endmodule
`default_nettype wire
